>>> rtl/core/bae_pkg.sv
// Package for the bounded array engine: sizes, operation and status codes,
// request and response structs and the sequencer state type. No dependencies.
package bae_pkg;

   localparam int Capacity = 16;
   localparam int IdxW     = $clog2(Capacity);
   localparam int CntW     = $clog2(Capacity + 1);

   typedef enum logic [3:0] {
      OP_APPEND = 4'd0, OP_INSERT = 4'd1, OP_DELETE = 4'd2, OP_GET = 4'd3,
      OP_SET = 4'd4, OP_SEARCH = 4'd5, OP_SEARCH_TR = 4'd6, OP_SEARCH_HD = 4'd7,
      OP_BSEARCH = 4'd8, OP_MAX = 4'd9, OP_MIN = 4'd10, OP_SUM = 4'd11,
      OP_REVERSE = 4'd12, OP_RSV13 = 4'd13, OP_RSV14 = 4'd14, OP_RSV15 = 4'd15
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_BADIDX = 3'd1, ST_FULL = 3'd2, ST_NOTFOUND = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic [4:0]         position;
      logic signed [31:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] result_value;
      logic [3:0]         result_index;
      logic [4:0]         element_count;
   } rsp_type;

   // RD issues a read, RW waits for its data and decides, WB2 writes one word.
   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_RW, S_WB2, S_DONE
   } state_type;

endpackage

>>> rtl/core/bounded_array_engine.sv
// Top level of the bounded array engine: a 16-word array in one synchronous
// memory walked by a small sequencer. Depends on bae_pkg.
//
//   channel  direction  handshake          payload
//   req      in         start / busy       req_type
//   rsp      out        rsp_valid strobe   rsp_type
//   csr      in         csr_valid/ready    capacity_in_use, 5 bits
//
// Each transaction makes at most one memory access per cycle. Append, set, errors
// and unused codes respond without a memory read; get reads one word; shifts,
// searches, max, min and sum read one element at a time; reverse reads and swaps
// pairs from both ends; binary search reads one word per probe. The next start is
// taken in the cycle after the strobe.
// Reset clears the count and sets capacity to 16; array contents are undefined.
// The response is a one-cycle strobe; the receiver cannot stall it.
module bounded_array_engine
   import bae_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [4:0] csr_data
);

   localparam logic [CntW-1:0] CapFull = CntW'(Capacity);

   // Element memory, read data registered.
   logic [31:0] mem [Capacity];
   logic [31:0] rd_data;
   logic        mem_re, mem_we;
   logic [IdxW-1:0] rd_addr, wr_addr;
   logic [31:0] wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      if (mem_re) rd_data <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic [CntW-1:0] cnt_ff, cnt_in, cap_ff, cap_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in, pos_ff, pos_in;
   logic signed [CntW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [31:0] key_ff, key_in, acc_ff, acc_in, hold_ff, hold_in;
   logic [2:0]  st_ff, st_in;
   logic [IdxW-1:0] ridx_ff, ridx_in;
   logic        ph_ff, ph_in;   // second read of a swap pair, or shift phase of delete
   logic        first_ff, first_in;

   // Always taken; configuration is to be written only while idle, unchecked.
   assign csr_ready = 1'b1;
   always_comb cap_in = csr_valid ? csr_data : cap_ff;
   always_ff @(posedge clock) begin
      if (reset) cap_ff <= CapFull;
      else cap_ff <= cap_in;
   end
   logic [CntW-1:0] cap_now;
   always_comb cap_now = (cap_ff < CapFull) ? cap_ff : CapFull;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      op_ff <= op_in; i_ff <= i_in; j_ff <= j_in; pos_ff <= pos_in;
      lo_ff <= lo_in; hi_ff <= hi_in; key_ff <= key_in; acc_ff <= acc_in;
      hold_ff <= hold_in; st_ff <= st_in; ridx_ff <= ridx_in; ph_ff <= ph_in;
      first_ff <= first_in;
   end

   logic signed [CntW:0] mid;
   always_comb mid = (lo_ff + hi_ff) >>> 1;

   // Sequencer: next state, memory controls and response.
   always_comb begin
      state_in = state_ff; op_in = op_ff; cnt_in = cnt_ff; i_in = i_ff;
      j_in = j_ff; pos_in = pos_ff; lo_in = lo_ff; hi_in = hi_ff;
      key_in = key_ff; acc_in = acc_ff; hold_in = hold_ff; st_in = st_ff;
      ridx_in = ridx_ff; ph_in = ph_ff; first_in = first_ff;
      mem_re = 1'b0; mem_we = 1'b0; rd_addr = '0; wr_addr = '0; wr_data = key_ff;
      rsp_valid = 1'b0;
      rsp_data = '{status: st_ff, result_value: acc_ff,
                   result_index: ridx_ff, element_count: cnt_ff};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = op_type'(req_data.operation);
               pos_in = req_data.position;
               key_in = req_data.operand_value;
               acc_in = '0; st_in = ST_OK; ridx_in = '0; ph_in = 1'b0;
               first_in = 1'b1;
               state_in = S_DONE;
               case (op_type'(req_data.operation))
                  OP_APPEND: begin
                     if (cnt_ff >= cap_now) st_in = ST_FULL;
                     else begin
                        mem_we = 1'b1; wr_addr = cnt_ff[IdxW-1:0];
                        wr_data = req_data.operand_value; cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     if (req_data.position > cnt_ff) st_in = ST_BADIDX;
                     else if (cnt_ff >= cap_now) st_in = ST_FULL;
                     else begin
                        i_in = cnt_ff; state_in = S_RD;   // move i-1 to i
                     end
                  end
                  OP_DELETE, OP_GET, OP_SET: begin
                     if (req_data.position >= cnt_ff) st_in = ST_BADIDX;
                     else if (op_type'(req_data.operation) == OP_SET) begin
                        mem_we = 1'b1; wr_addr = req_data.position[IdxW-1:0];
                        wr_data = req_data.operand_value;
                     end else begin
                        i_in = req_data.position; state_in = S_RD;
                     end
                  end
                  OP_SEARCH, OP_SEARCH_TR, OP_SEARCH_HD: begin
                     i_in = '0; st_in = ST_NOTFOUND;
                     if (cnt_ff != '0) state_in = S_RD;
                  end
                  OP_BSEARCH: begin
                     st_in = ST_NOTFOUND; lo_in = '0;
                     hi_in = (CntW+1)'($signed({1'b0, cnt_ff}) - 1);
                     if (cnt_ff != '0) state_in = S_RD;
                  end
                  OP_MAX, OP_MIN: begin
                     i_in = '0;
                     if (cnt_ff == '0) st_in = ST_EMPTY; else state_in = S_RD;
                  end
                  OP_SUM: begin
                     i_in = '0;
                     if (cnt_ff != '0) state_in = S_RD;
                  end
                  OP_REVERSE: begin
                     i_in = '0; j_in = cnt_ff - 1'b1;
                     if (cnt_ff > 1) state_in = S_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            mem_re = 1'b1; state_in = S_RW;
            case (op_ff)
               OP_INSERT: rd_addr = IdxW'(i_ff - 1'b1);
               OP_DELETE: rd_addr = IdxW'(ph_ff ? i_ff + 1'b1 : i_ff);
               OP_BSEARCH: rd_addr = mid[IdxW-1:0];
               OP_SEARCH_TR, OP_SEARCH_HD, OP_REVERSE:
                  rd_addr = ph_ff ? j_ff[IdxW-1:0] : i_ff[IdxW-1:0];
               default: rd_addr = i_ff[IdxW-1:0];
            endcase
         end
         S_RW: begin
            state_in = S_RD;
            case (op_ff)
               OP_INSERT: begin
                  if (i_ff > pos_ff) begin
                     mem_we = 1'b1; wr_addr = i_ff[IdxW-1:0]; wr_data = rd_data;
                     i_in = i_ff - 1'b1;
                     if (i_ff - 1'b1 == pos_ff) state_in = S_WB2;
                  end else state_in = S_WB2;
               end
               OP_GET: begin acc_in = rd_data; state_in = S_DONE; end
               OP_DELETE: begin
                  if (!ph_ff) begin
                     acc_in = rd_data; ph_in = 1'b1;
                     if (i_ff + 1'b1 >= cnt_ff) begin
                        cnt_in = cnt_ff - 1'b1; state_in = S_DONE;
                     end
                  end else begin
                     mem_we = 1'b1; wr_addr = i_ff[IdxW-1:0]; wr_data = rd_data;
                     i_in = i_ff + 1'b1;
                     if (i_ff + 2'd2 >= cnt_ff) begin
                        cnt_in = cnt_ff - 1'b1; state_in = S_DONE;
                     end
                  end
               end
               OP_SEARCH, OP_SEARCH_TR, OP_SEARCH_HD: begin
                  if (!ph_ff) begin
                     if (rd_data == key_ff) begin
                        st_in = ST_OK; ridx_in = i_ff[IdxW-1:0];
                        if (op_ff == OP_SEARCH || i_ff == '0) state_in = S_DONE;
                        else begin
                           ph_in = 1'b1;
                           j_in = (op_ff == OP_SEARCH_TR) ? i_ff - 1'b1 : '0;
                        end
                     end else if (i_ff + 1'b1 >= cnt_ff) state_in = S_DONE;
                     else i_in = i_ff + 1'b1;
                  end else begin
                     // slot i holds key; write partner into i, key into j
                     mem_we = 1'b1; wr_addr = i_ff[IdxW-1:0]; wr_data = rd_data;
                     state_in = S_WB2;
                  end
               end
               OP_BSEARCH: begin
                  if (rd_data == key_ff) begin
                     st_in = ST_OK; ridx_in = mid[IdxW-1:0]; state_in = S_DONE;
                  end else begin
                     if ($signed(key_ff) < $signed(rd_data)) begin
                        hi_in = (CntW+1)'(mid - 1);
                        if (lo_ff > mid - 1) state_in = S_DONE;
                     end else begin
                        lo_in = (CntW+1)'(mid + 1);
                        if (mid + 1 > hi_ff) state_in = S_DONE;
                     end
                  end
               end
               OP_MAX, OP_MIN, OP_SUM: begin
                  if (op_ff == OP_SUM) acc_in = acc_ff + rd_data;
                  else if (first_ff) acc_in = rd_data;
                  else if (op_ff == OP_MAX ? ($signed(acc_ff) < $signed(rd_data))
                                           : ($signed(rd_data) < $signed(acc_ff)))
                     acc_in = rd_data;
                  first_in = 1'b0;
                  i_in = i_ff + 1'b1;
                  if (i_ff + 1'b1 >= cnt_ff) state_in = S_DONE;
               end
               OP_REVERSE: begin
                  if (!ph_ff) begin hold_in = rd_data; ph_in = 1'b1; end
                  else begin
                     mem_we = 1'b1; wr_addr = i_ff[IdxW-1:0]; wr_data = rd_data;
                     state_in = S_WB2;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_WB2: begin
            mem_we = 1'b1; state_in = S_DONE;
            case (op_ff)
               OP_INSERT: begin
                  wr_addr = pos_ff[IdxW-1:0]; wr_data = key_ff;
                  cnt_in = cnt_ff + 1'b1;
               end
               OP_REVERSE: begin
                  wr_addr = j_ff[IdxW-1:0]; wr_data = hold_ff; ph_in = 1'b0;
                  i_in = i_ff + 1'b1; j_in = j_ff - 1'b1;
                  if (i_ff + 1'b1 < j_ff - 1'b1) state_in = S_RD;
               end
               default: begin wr_addr = j_ff[IdxW-1:0]; wr_data = key_ff; end
            endcase
         end
         S_DONE: begin
            rsp_valid = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   // The count never exceeds the array depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CapFull) else $error("element count above depth");
   // A response comes only at the end of a transaction.
   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after response");
   // No memory read is issued in the idle state.
   a_idle_rd: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !mem_re) else $error("read while idle");
   // The count changes only when a request is accepted or one is in progress.
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> $stable(cnt_ff)) else $error("count changed idle");

endmodule
